// File: rtl/dbsg_pkg.sv
// Shared constants, types and tables of the de Bruijn sequence generator.
`timescale 1ns / 1ps
package dbsg_pkg;

  localparam int MAX_ORDER    = 8;
  localparam int DIGIT_BITS   = 4;
  localparam int PTR_BITS     = 3;
  localparam int K_BITS       = 5;
  localparam int N_BITS       = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = 5;

  localparam logic [K_BITS-1:0] MAX_K = 5'd16;
  localparam logic [K_BITS-1:0] MIN_K = 5'd2;
  localparam logic [N_BITS-1:0] MAX_N = 4'd8;

  localparam logic [CFG_IDX_BITS-1:0] REG_ALPHABET = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORDER    = 2'd1;

  // Row n-1: bit i-1 set when i divides n.
  localparam logic [MAX_ORDER-1:0] DIV_MASK [MAX_ORDER] = '{
    8'b0000_0001,
    8'b0000_0011,
    8'b0000_0101,
    8'b0000_1011,
    8'b0001_0001,
    8'b0010_0111,
    8'b0100_0001,
    8'b1000_1011
  };

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_COPY = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic                  clear;
    logic                  we;
    logic [PTR_BITS-1:0]   waddr;
    logic [DIGIT_BITS-1:0] wdata;
  } wr_t;

endpackage

// File: rtl/dbsg_digits.sv
// Digit register file of the current prenecklace, one read and one write port.
`timescale 1ns / 1ps
module dbsg_digits (
  input  logic                           clk,
  input  logic                           rst,
  input  dbsg_pkg::wr_t                  wr,
  input  logic [dbsg_pkg::PTR_BITS-1:0]  raddr,
  output logic [dbsg_pkg::DIGIT_BITS-1:0] rdata
);

  logic [dbsg_pkg::DIGIT_BITS-1:0] mem [dbsg_pkg::MAX_ORDER];

  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      for (int e = 0; e < dbsg_pkg::MAX_ORDER; e++) begin
        mem[e] <= '0;
      end
    end else if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
  end

  assign rdata = mem[raddr];

endmodule

// File: rtl/dbsg_seq.sv
// Sequencer: request handling, successor search over the digit file, result register.
`timescale 1ns / 1ps
module dbsg_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_rewind,
  input  logic [dbsg_pkg::DIGIT_BITS-1:0] k_m1,
  input  logic [dbsg_pkg::PTR_BITS-1:0]   n_m1,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            restart,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [dbsg_pkg::DIGIT_BITS-1:0] digit,
  output logic                            last
);

  dbsg_pkg::state_t state;

  logic [dbsg_pkg::PTR_BITS-1:0]   i_ptr;
  logic [dbsg_pkg::PTR_BITS-1:0]   j_ptr;
  logic [dbsg_pkg::PTR_BITS-1:0]   src_ptr;
  logic [dbsg_pkg::PTR_BITS-1:0]   p_m1;
  logic [dbsg_pkg::PTR_BITS-1:0]   e_m1;
  logic                            in_tail;
  logic [dbsg_pkg::PTR_BITS-1:0]   tail_count;
  logic [dbsg_pkg::DIGIT_BITS-1:0] res_digit;
  logic                            res_last;

  dbsg_pkg::wr_t                   wr;
  logic [dbsg_pkg::PTR_BITS-1:0]   raddr;
  logic [dbsg_pkg::DIGIT_BITS-1:0] rd;

  logic                            out_free;
  logic                            accept;
  logic                            rsp_load;
  logic                            tail_e;
  logic [dbsg_pkg::PTR_BITS:0]     tail_next;
  logic                            tail_done;
  logic [dbsg_pkg::DIGIT_BITS-1:0] digit_e;
  logic [dbsg_pkg::PTR_BITS-1:0]   idx_e;
  logic [dbsg_pkg::PTR_BITS-1:0]   p_e;
  logic                            at_max;
  logic                            words_done;

  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = cfg_rewind || !((state == dbsg_pkg::S_IDLE) && out_free);
  assign accept     = req_valid && !req_stall;
  assign tail_e     = in_tail && !restart;
  assign tail_next  = {1'b0, tail_count} + {{dbsg_pkg::PTR_BITS{1'b0}}, 1'b1};
  assign tail_done  = tail_next >= {1'b0, n_m1};
  assign digit_e    = restart ? '0 : rd;
  assign idx_e      = restart ? '0 : e_m1;
  assign p_e        = restart ? '0 : p_m1;
  assign at_max     = rd >= k_m1;
  assign words_done = (state == dbsg_pkg::S_SCAN) && at_max && (i_ptr == '0);
  assign rsp_load   = !cfg_rewind &&
                      ((accept && (tail_e || (idx_e < p_e))) ||
                       ((state == dbsg_pkg::S_DONE) && out_free));

  always_comb begin
    unique case (state)
      dbsg_pkg::S_IDLE: raddr = e_m1;
      dbsg_pkg::S_SCAN: raddr = i_ptr;
      dbsg_pkg::S_COPY: raddr = src_ptr;
      default:          raddr = '0;
    endcase
  end

  always_comb begin
    wr.clear = cfg_rewind || (accept && restart) || (accept && tail_e && tail_done) ||
               (words_done && (n_m1 == '0));
    wr.we    = 1'b0;
    wr.waddr = i_ptr;
    wr.wdata = rd + {{(dbsg_pkg::DIGIT_BITS-1){1'b0}}, 1'b1};
    if (state == dbsg_pkg::S_SCAN && !at_max) begin
      wr.we = 1'b1;
    end else if (state == dbsg_pkg::S_COPY) begin
      wr.we    = 1'b1;
      wr.waddr = j_ptr;
      wr.wdata = rd;
    end
  end

  dbsg_digits u_digits (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dbsg_pkg::S_IDLE;
      p_m1       <= '0;
      e_m1       <= '0;
      in_tail    <= 1'b0;
      tail_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      if (cfg_rewind) begin
        p_m1       <= '0;
        e_m1       <= '0;
        in_tail    <= 1'b0;
        tail_count <= '0;
      end else begin
        unique case (state)
          dbsg_pkg::S_IDLE: begin
            if (accept) begin
              if (tail_e) begin
                digit <= '0;
                if (tail_done) begin
                  last       <= 1'b1;
                  p_m1       <= '0;
                  e_m1       <= '0;
                  in_tail    <= 1'b0;
                  tail_count <= '0;
                end else begin
                  last       <= 1'b0;
                  tail_count <= tail_next[dbsg_pkg::PTR_BITS-1:0];
                end
              end else if (idx_e >= p_e) begin
                res_digit  <= digit_e;
                i_ptr      <= n_m1;
                in_tail    <= 1'b0;
                tail_count <= '0;
                state      <= dbsg_pkg::S_SCAN;
              end else begin
                digit <= digit_e;
                last  <= 1'b0;
                e_m1  <= idx_e + 1'b1;
              end
            end
          end
          dbsg_pkg::S_SCAN: begin
            if (at_max) begin
              if (i_ptr == '0) begin
                if (n_m1 != '0) begin
                  in_tail    <= 1'b1;
                  tail_count <= '0;
                  res_last   <= 1'b0;
                end else begin
                  res_last   <= 1'b1;
                  p_m1       <= '0;
                  e_m1       <= '0;
                  in_tail    <= 1'b0;
                  tail_count <= '0;
                end
                state <= dbsg_pkg::S_DONE;
              end else begin
                i_ptr <= i_ptr - 1'b1;
              end
            end else begin
              p_m1 <= i_ptr;
              if (i_ptr == n_m1) begin
                e_m1     <= '0;
                res_last <= 1'b0;
                state    <= dbsg_pkg::S_DONE;
              end else begin
                j_ptr   <= i_ptr + 1'b1;
                src_ptr <= '0;
                state   <= dbsg_pkg::S_COPY;
              end
            end
          end
          dbsg_pkg::S_COPY: begin
            if (j_ptr == n_m1) begin
              if (dbsg_pkg::DIV_MASK[n_m1][i_ptr]) begin
                e_m1     <= '0;
                res_last <= 1'b0;
                state    <= dbsg_pkg::S_DONE;
              end else begin
                i_ptr <= n_m1;
                state <= dbsg_pkg::S_SCAN;
              end
            end else begin
              j_ptr   <= j_ptr + 1'b1;
              src_ptr <= src_ptr + 1'b1;
            end
          end
          dbsg_pkg::S_DONE: begin
            if (out_free) begin
              digit <= res_digit;
              last  <= res_last;
              state <= dbsg_pkg::S_IDLE;
            end
          end
          default: state <= dbsg_pkg::S_IDLE;
        endcase
      end
    end
  end

endmodule

// File: rtl/de_bruijn_sequence_generator.sv
// de Bruijn sequence generator: configuration registers and sequencer.
//
// Each request (req_valid, restart) returns one digit of the de Bruijn
// sequence of order n over k symbols, followed by n-1 wrap zeros; last marks
// the final digit, after which the next request starts a fresh sequence.
// restart = 1 rewinds to the sequence start before emitting.
// Configuration: cfg_write with cfg_index 0 (alphabet size) or 1 (order)
// writes cfg_data and rewinds the generator; write only while idle.
// A digit taken from inside the current word is registered and shown in
// the cycle after the request. The last digit of a word runs the successor
// search on the digit file's single read port: one digit per cycle to scan
// back, one per cycle to copy the period forward, repeated for each word
// whose period does not divide n; the result is then presented from the
// result register. The request side is stalled while a search runs, during
// a configuration write to index 0 or 1, or while the response register is
// full and stalled; a new request is taken while a finished response is
// being taken. Reset sets k = 2, n = 3 and rewinds.
`timescale 1ns / 1ps
module de_bruijn_sequence_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dbsg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [dbsg_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                restart,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [dbsg_pkg::DIGIT_BITS-1:0]     digit,
  output logic                                last
);

  logic [dbsg_pkg::K_BITS-1:0]     alphabet_size;
  logic [dbsg_pkg::N_BITS-1:0]     order;
  logic [dbsg_pkg::K_BITS-1:0]     k_eff;
  logic [dbsg_pkg::N_BITS-1:0]     n_eff;
  logic [dbsg_pkg::K_BITS-1:0]     k_dec;
  logic [dbsg_pkg::N_BITS-1:0]     n_dec;
  logic [dbsg_pkg::DIGIT_BITS-1:0] k_m1;
  logic [dbsg_pkg::PTR_BITS-1:0]   n_m1;
  logic                            cfg_rewind;

  assign cfg_rewind = cfg_write &&
                      (cfg_index == dbsg_pkg::REG_ALPHABET || cfg_index == dbsg_pkg::REG_ORDER);

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= dbsg_pkg::MIN_K;
      order         <= 4'd3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dbsg_pkg::REG_ALPHABET: alphabet_size <= cfg_data[dbsg_pkg::K_BITS-1:0];
        dbsg_pkg::REG_ORDER:    order         <= cfg_data[dbsg_pkg::N_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign k_eff = (alphabet_size < dbsg_pkg::MIN_K) ? dbsg_pkg::MIN_K :
                 (alphabet_size > dbsg_pkg::MAX_K) ? dbsg_pkg::MAX_K : alphabet_size;
  assign n_eff = (order == '0) ? 4'd1 :
                 (order > dbsg_pkg::MAX_N) ? dbsg_pkg::MAX_N : order;
  assign k_dec = k_eff - 1'b1;
  assign n_dec = n_eff - 1'b1;
  assign k_m1  = k_dec[dbsg_pkg::DIGIT_BITS-1:0];
  assign n_m1  = n_dec[dbsg_pkg::PTR_BITS-1:0];

  dbsg_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_rewind (cfg_rewind),
    .k_m1       (k_m1),
    .n_m1       (n_m1),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .restart    (restart),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .digit      (digit),
    .last       (last)
  );

endmodule
